/* hdl/tun_pkg.sv */
// Shared types and widths for the triangle unit normal pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package tun_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_OUT   = 14;
  localparam int OUT_W      = 16;
  localparam int NUM_COORD  = 9;

  localparam int DW   = COORD_BITS + 1;       // edge component
  localparam int PW   = 2 * DW;               // edge product
  localparam int MW   = PW + 1;               // cross component magnitude
  localparam int LO   = (MW + 1) / 2;         // low split of a magnitude
  localparam int HI   = MW - LO;              // high split of a magnitude
  localparam int SW   = 2 * MW + 2;           // sum of squares, kept even
  localparam int RW   = SW / 2;               // square root width
  localparam int QW   = FRAC_OUT + 1;         // quotient bits
  localparam int DVW  = RW + FRAC_OUT;        // shifted divisor and remainder

  localparam int IN_W  = ((NUM_COORD * COORD_BITS + 7) / 8) * 8;
  localparam int OUTD_W = ((3 * OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic                 valid;
    logic                 degen;
    logic [2:0]           neg;
    logic [2:0][MW-1:0]   mag;
    logic [SW-1:0]        rad;
    logic [SW-1:0]        res;
    logic [SW-1:0]        probe;
  } sq_t;

  typedef struct packed {
    logic                 valid;
    logic                 degen;
    logic [2:0]           neg;
    logic [2:0][DVW-1:0]  rem;
    logic [DVW-1:0]       dvs;
    logic [2:0][QW-1:0]   quo;
  } dv_t;

endpackage

/* hdl/tun_front.sv */
// Front end: edge vectors, cross product and sum of squares over six stages.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_front import tun_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IN_W-1:0] in_data,
  output sq_t             sq_out
);

  logic [5:0] v_r;

  logic signed [DW-1:0] e_r [6];           // ux uy uz vx vy vz
  logic signed [PW-1:0] p_r [6];
  logic [2:0]           neg3_r, neg4_r, neg5_r, neg6_r;
  logic [MW-1:0]        mag3_r [3], mag4_r [3], mag5_r [3], mag6_r [3];
  logic                 dg3_r, dg4_r, dg5_r, dg6_r;
  logic [2*HI-1:0]      hh_r [3];
  logic [HI+LO-1:0]     hl_r [3];
  logic [2*LO-1:0]      ll_r [3];
  logic [SW-1:0]        sqv_r [3];
  logic [SW-1:0]        sum_r;

  logic signed [COORD_BITS:0] cx [NUM_COORD];
  logic signed [MW-1:0]       cr [3];
  logic [MW-1:0]              cm [3];

  always_comb begin
    for (int k = 0; k < NUM_COORD; k++) begin
      cx[k] = $signed({in_data[k*COORD_BITS + COORD_BITS - 1],
                       in_data[k*COORD_BITS +: COORD_BITS]});
    end
    cr[0] = MW'(p_r[0]) - MW'(p_r[1]);
    cr[1] = MW'(p_r[2]) - MW'(p_r[3]);
    cr[2] = MW'(p_r[4]) - MW'(p_r[5]);
    for (int i = 0; i < 3; i++) begin
      cm[i] = cr[i][MW-1] ? MW'(-cr[i]) : MW'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= DW'(cx[3] - cx[0]);
      e_r[1] <= DW'(cx[4] - cx[1]);
      e_r[2] <= DW'(cx[5] - cx[2]);
      e_r[3] <= DW'(cx[6] - cx[0]);
      e_r[4] <= DW'(cx[7] - cx[1]);
      e_r[5] <= DW'(cx[8] - cx[2]);

      p_r[0] <= e_r[1] * e_r[5];
      p_r[1] <= e_r[2] * e_r[4];
      p_r[2] <= e_r[2] * e_r[3];
      p_r[3] <= e_r[0] * e_r[5];
      p_r[4] <= e_r[0] * e_r[4];
      p_r[5] <= e_r[1] * e_r[3];

      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= cr[i][MW-1];
        mag3_r[i] <= cm[i];
        hh_r[i]   <= mag3_r[i][MW-1:LO] * mag3_r[i][MW-1:LO];
        hl_r[i]   <= mag3_r[i][MW-1:LO] * mag3_r[i][LO-1:0];
        ll_r[i]   <= mag3_r[i][LO-1:0] * mag3_r[i][LO-1:0];
        sqv_r[i]  <= (SW'(hh_r[i]) << (2 * LO)) + (SW'(hl_r[i]) << (LO + 1))
                     + SW'(ll_r[i]);
        mag4_r[i] <= mag3_r[i];
        mag5_r[i] <= mag4_r[i];
        mag6_r[i] <= mag5_r[i];
      end
      dg3_r  <= (cm[0] == '0) && (cm[1] == '0) && (cm[2] == '0);
      dg4_r  <= dg3_r;
      dg5_r  <= dg4_r;
      dg6_r  <= dg5_r;
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      sum_r  <= sqv_r[0] + sqv_r[1] + sqv_r[2];
    end
  end

  always_comb begin
    sq_out.valid = v_r[5];
    sq_out.degen = dg6_r;
    sq_out.neg   = neg6_r;
    for (int i = 0; i < 3; i++) sq_out.mag[i] = mag6_r[i];
    sq_out.rad   = sum_r;
    sq_out.res   = '0;
    sq_out.probe = SW'(1) << (SW - 2);
  end

endmodule

/* hdl/tun_sqrt_cell.sv */
// One digit step of the integer square root, registered.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_sqrt_cell import tun_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  sq_t  d_in,
  output sq_t  d_out
);

  sq_t        d_r;
  logic [SW-1:0] trial;
  logic          take;

  // res and probe never overlap, so their sum is an OR
  assign trial = d_in.res | d_in.probe;
  assign take  = d_in.rad >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_in.valid;
    end
    if (en) begin
      d_r.degen <= d_in.degen;
      d_r.neg   <= d_in.neg;
      d_r.mag   <= d_in.mag;
      d_r.rad   <= take ? d_in.rad - trial : d_in.rad;
      d_r.res   <= take ? (d_in.res >> 1) | d_in.probe : d_in.res >> 1;
      d_r.probe <= d_in.probe >> 2;
    end
  end

  assign d_out = d_r;

endmodule

/* hdl/tun_div_cell.sv */
// One quotient bit of three restoring divisions sharing a divisor, registered.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_div_cell import tun_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  dv_t  d_in,
  output dv_t  d_out
);

  dv_t        d_r;
  logic [2:0] take;

  always_comb begin
    for (int i = 0; i < 3; i++) take[i] = d_in.rem[i] >= d_in.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_in.valid;
    end
    if (en) begin
      d_r.degen <= d_in.degen;
      d_r.neg   <= d_in.neg;
      d_r.dvs   <= d_in.dvs >> 1;
      for (int i = 0; i < 3; i++) begin
        d_r.rem[i] <= take[i] ? d_in.rem[i] - d_in.dvs : d_in.rem[i];
        d_r.quo[i] <= {d_in.quo[i][QW-2:0], take[i]};
      end
    end
  end

  assign d_out = d_r;

endmodule

/* hdl/triangle_unit_normal_unit.sv */
// Triangle unit normal: Q8.8 corners in, Q1.14 unit face normal out.
// Stages: front end, root cell chain, divider cell chain, output register; one transaction
// per cycle sustained unless the output is held, set by the fully pipelined cell chains.
// The whole chain advances together and stalls only when the output is held.
// Reset (synchronous, rst_n low) clears every stage valid bit; payload is not reset.
// Depends on tun_pkg, tun_front, tun_sqrt_cell, tun_div_cell.
`timescale 1ns / 1ps
module triangle_unit_normal_unit import tun_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz (COORD_BITS each, from bit 0 up)
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // nx, ny, nz (16 bits each, from bit 0 up)
  output logic [OUTD_W-1:0] out_tdata,
  // degenerate
  output logic              out_tuser
);

  logic en;
  sq_t  sq_c [RW+1];
  dv_t  dv_c [QW+1];

  logic              out_valid_r;
  logic [OUTD_W-1:0] out_data_r;
  logic              out_degen_r;
  logic [OUTD_W-1:0] out_data_nxt;

  // Advance the whole chain unless a finished result is being held
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  tun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .sq_out   (sq_c[0])
  );

  // Square root chain: one result bit per cell
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (sq_c[g]),
      .d_out (sq_c[g+1])
    );
  end

  // Seed the divider: numerators scaled by 2^14, divisor aligned to the top quotient bit
  always_comb begin
    dv_c[0].valid = sq_c[RW].valid;
    dv_c[0].degen = sq_c[RW].degen;
    dv_c[0].neg   = sq_c[RW].neg;
    dv_c[0].dvs   = DVW'(sq_c[RW].res[RW-1:0]) << FRAC_OUT;
    for (int i = 0; i < 3; i++) begin
      dv_c[0].rem[i] = DVW'(sq_c[RW].mag[i]) << FRAC_OUT;
      dv_c[0].quo[i] = '0;
    end
  end

  // Divider chain: one quotient bit per cell, three components side by side
  for (genvar g = 0; g < QW; g++) begin : g_div
    tun_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (dv_c[g]),
      .d_out (dv_c[g+1])
    );
  end

  // Apply sign; drop the quotient for a degenerate triangle
  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (!dv_c[QW].degen) begin
        out_data_nxt[i*OUT_W +: OUT_W] = dv_c[QW].neg[i]
          ? OUT_W'(-{1'b0, dv_c[QW].quo[i]})
          : OUT_W'({1'b0, dv_c[QW].quo[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_c[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= out_data_nxt;
      out_degen_r <= dv_c[QW].degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result carries a nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[OUT_W-1:0]) <= 16384)
                && ($signed(out_tdata[OUT_W-1:0]) >= -16384)
                && ($signed(out_tdata[2*OUT_W-1:OUT_W]) <= 16384)
                && ($signed(out_tdata[2*OUT_W-1:OUT_W]) >= -16384)
                && ($signed(out_tdata[3*OUT_W-1:2*OUT_W]) <= 16384)
                && ($signed(out_tdata[3*OUT_W-1:2*OUT_W]) >= -16384))
    else $error("normal component outside unit range");

  // Hold a stalled result steady until it is taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("held result changed during stall");

endmodule
